/* hw/rtl/smbl_pkg.sv */
// Shared types, codes and CORDIC helpers for the sky map bilinear lookup.
// No dependencies; imported by sky_map_bilinear_lookup_top, smbl_acos and the testbench.
package smbl_pkg;

    localparam int CORDIC_STEPS = 15;
    localparam int ANG_W        = 18;
    localparam int XY_W         = 27;

    localparam logic [7:0] CFG_ROWS = 8'd0;
    localparam logic [7:0] CFG_COLS = 8'd1;
    localparam logic [7:0] CFG_SUN  = 8'd2;
    localparam logic [7:0] CFG_BYTE = 8'd3;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic        done;
        logic [15:0] ang;
        logic [15:0] root;
    } acos_rsp_t;

    function automatic logic signed [ANG_W-1:0] atan_step(input logic [3:0] i);
        logic signed [ANG_W-1:0] r;
        unique case (i)
            4'd0:    r = 18'sd8192;
            4'd1:    r = 18'sd4836;
            4'd2:    r = 18'sd2555;
            4'd3:    r = 18'sd1297;
            4'd4:    r = 18'sd651;
            4'd5:    r = 18'sd326;
            4'd6:    r = 18'sd163;
            4'd7:    r = 18'sd81;
            4'd8:    r = 18'sd41;
            4'd9:    r = 18'sd20;
            4'd10:   r = 18'sd10;
            4'd11:   r = 18'sd5;
            4'd12:   r = 18'sd3;
            4'd13:   r = 18'sd1;
            4'd14:   r = 18'sd1;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

    // shift right, rounding toward zero
    function automatic logic signed [XY_W-1:0] shr_tz(input logic signed [XY_W-1:0] v,
                                                      input logic [3:0] k);
        logic signed [XY_W-1:0] r;
        if (v < 0)
            r = -((-v) >>> k);
        else
            r = v >>> k;
        return r;
    endfunction

endpackage

/* hw/rtl/sky_map_bilinear_lookup_top.sv */
// Equirectangular sky map lookup with bilinear blend over a texel RAM.
// Depends on smbl_pkg, smbl_ram, smbl_acos.
//
// Usage:
//   s_axis carries write words (tuser 0: store texel_value at texel_addr) and
//   lookup words (tuser 1: ray direction and frame). Each lookup yields one
//   word on m_axis; writes yield none. cfg_* writes sky_rows, sky_cols,
//   sun_azimuth and byte_texels; write it only while the block is idle.
//   A write is taken back to back with the next word.
//   A lookup above the horizon runs two 16-step square roots, two 15-step
//   CORDIC passes and a 31-step divider, all one step per cycle, then four
//   texel reads on the single RAM port and two blend steps, which an address
//   error skips. Column wrapping repeats its step until the column is in range.
//   The divider and the second acos are skipped when the first root is zero.
//   A ray below the horizon goes straight to the output state. Lookups run
//   one at a time. One word waits in an input register while a lookup runs,
//   and the result sits in an output register, so a stalled m_axis holds its
//   word and the next input is still taken.
//   Reset clears the control state and sets the config registers to 64 rows,
//   128 columns, sun azimuth 0 and byte texels. The texel RAM is not cleared.
module sky_map_bilinear_lookup_top #(
    parameter int STORE_DEPTH = 65536,
    parameter int TEXEL_BITS  = 16,
    parameter int MAX_DIM     = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // texel_addr, texel_value, ray_x, ray_y, ray_z, frame
    input  logic [0:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // radiance
    output logic [1:0]  m_axis_tuser,  // below_horizon, address_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_addr,
    input  logic [15:0] cfg_data
);
    import smbl_pkg::*;

    localparam int AW      = $clog2(STORE_DEPTH);
    localparam int TQ_W    = (TEXEL_BITS > 16) ? TEXEL_BITS : 16;
    localparam int VA_W    = TQ_W + 9;
    localparam int SUM_W   = (VA_W + 10 > 41) ? VA_W + 10 : 41;
    localparam int DIM_CAP = (MAX_DIM > 511) ? 511 : MAX_DIM;
    localparam int ADDR_CW = 28;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_ZWAIT = 11'b00000000010,
        S_DIV   = 11'b00000000100,
        S_AWAIT = 11'b00000001000,
        S_POS1  = 11'b00000010000,
        S_POS2  = 11'b00000100000,
        S_WRAP  = 11'b00001000000,
        S_RD    = 11'b00010000000,
        S_BL1   = 11'b00100000000,
        S_BL2   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    // config
    logic [8:0]         rows_cfg_reg, cols_cfg_reg;
    logic signed [15:0] sun_reg;
    logic               byte_reg;
    logic [8:0]         rows, cols;

    // input holding register
    logic               hold_valid_reg, hold_valid_next;
    logic [87:0]        hold_data_reg;
    logic               hold_type_reg;
    logic               take;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [23:0]        out_rad_reg;
    logic               out_below_reg, out_err_reg;
    logic               out_load;

    state_t             state_reg, state_next;

    logic [15:0]        h_addr, h_value;
    logic signed [15:0] h_x, h_y, h_z;
    logic [7:0]         h_frame;

    logic               acos_start_reg;
    logic signed [16:0] acos_c_reg;
    acos_rsp_t          acos_rsp;

    logic signed [15:0] x_reg;
    logic               y_neg_reg;
    logic [7:0]         frame_reg;
    logic [15:0]        zen_reg, d_reg;
    logic signed [16:0] az_reg;

    logic [30:0]        num_reg;
    logic [15:0]        rem_reg;
    logic [30:0]        q_reg;
    logic [4:0]         cnt_reg;
    logic [16:0]        trial;
    logic               q_bit;
    logic [30:0]        q_new;
    logic [15:0]        mag;
    logic [15:0]        x_abs;

    logic [24:0]        rprod_reg;
    logic signed [27:0] cprod_reg;
    logic [17:0]        cr_reg;
    logic signed [17:0] diff;
    logic [10:0]        rraw;
    logic signed [21:0] cpos;

    logic [8:0]         r0_reg, r1_comb, c1_comb;
    logic signed [13:0] c0_reg;
    logic [8:0]         c0_u;
    logic [7:0]         dr_reg, dc_reg;
    logic [25:0]        base_reg;
    logic [17:0]        rowoff0_reg, rowoff1_reg;
    logic [8:0]         c1_reg;

    logic [2:0]         rd_cnt_reg;
    logic               err_reg;
    logic [ADDR_CW-1:0] rd_addr;
    logic               rd_bad;
    logic [TEXEL_BITS-1:0] tex_reg [4];
    logic [TQ_W-1:0]    tq [4];
    logic [VA_W-1:0]    va_reg, vb_reg;
    logic [SUM_W-1:0]   sum;
    logic [23:0]        res_reg;
    logic               below_reg, res_err_reg;

    logic               mem_en, mem_we;
    logic [AW-1:0]      mem_addr;
    logic [TEXEL_BITS-1:0] mem_wdata, mem_rdata;
    logic               wr_ok;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (rows_cfg_reg == 9'd0)
            rows = 9'd1;
        else if (rows_cfg_reg > 9'(DIM_CAP))
            rows = 9'(DIM_CAP);
        else
            rows = rows_cfg_reg;
        if (cols_cfg_reg == 9'd0)
            cols = 9'd1;
        else if (cols_cfg_reg > 9'(DIM_CAP))
            cols = 9'(DIM_CAP);
        else
            cols = cols_cfg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= 9'd64;
            cols_cfg_reg <= 9'd128;
            sun_reg      <= '0;
            byte_reg     <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                CFG_ROWS: rows_cfg_reg <= cfg_data[8:0];
                CFG_COLS: cols_cfg_reg <= cfg_data[8:0];
                CFG_SUN:  sun_reg      <= cfg_data;
                CFG_BYTE: byte_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input side
    assign take          = (state_reg == S_IDLE) && hold_valid_reg;
    assign s_axis_tready = !hold_valid_reg || (state_reg == S_IDLE);

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
            hold_valid_next = 1'b0;
        if (s_axis_tvalid && s_axis_tready)
            hold_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            hold_data_reg <= s_axis_tdata;
            hold_type_reg <= s_axis_tuser[0];
        end
    end

    assign h_addr  = hold_data_reg[15:0];
    assign h_value = hold_data_reg[31:16];
    assign h_x     = hold_data_reg[47:32];
    assign h_y     = hold_data_reg[63:48];
    assign h_z     = hold_data_reg[79:64];
    assign h_frame = hold_data_reg[87:80];

    smbl_acos u_acos (
        .clk   (clk),
        .rst_n (rst_n),
        .start (acos_start_reg),
        .c     (acos_c_reg),
        .rsp   (acos_rsp)
    );

    // divider step
    assign trial = {rem_reg, num_reg[30]};
    assign q_bit = (trial >= {1'b0, d_reg});
    assign q_new = {q_reg[29:0], q_bit};
    assign mag   = (q_new > 31'd32768) ? 16'h8000 : q_new[15:0];
    assign x_abs = (h_x < 0) ? 16'(-h_x) : 16'(h_x);

    // position
    assign diff = 18'(az_reg) - 18'(sun_reg);
    assign rraw = rprod_reg[24:14];
    assign cpos = 22'(cprod_reg >>> 8) + 22'({cols, 7'd0});
    assign c0_u = c0_reg[8:0];
    assign r1_comb = (r0_reg + 9'd1 == rows) ? 9'd0 : r0_reg + 9'd1;
    assign c1_comb = (c0_u + 9'd1 == cols) ? 9'd0 : c0_u + 9'd1;

    // texel reads
    assign rd_addr = ADDR_CW'(base_reg) + ADDR_CW'(rd_cnt_reg[1] ? rowoff1_reg : rowoff0_reg)
                   + ADDR_CW'(rd_cnt_reg[0] ? c1_reg : c0_u);
    assign rd_bad  = (rd_addr >= ADDR_CW'(STORE_DEPTH));
    assign wr_ok   = (ADDR_CW'(h_addr) < ADDR_CW'(STORE_DEPTH));

    always_comb
    begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = rd_addr[AW-1:0];
        mem_wdata = TEXEL_BITS'(h_value);
        if (take && hold_type_reg == REQ_WRITE)
        begin
            mem_en   = wr_ok;
            mem_we   = 1'b1;
            mem_addr = AW'(h_addr);
        end
        else if (state_reg == S_RD && !rd_cnt_reg[2] && !rd_bad)
            mem_en = 1'b1;
    end

    smbl_ram #(
        .WIDTH (TEXEL_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            tq[k] = byte_reg ? TQ_W'({tex_reg[k][7:0], 8'h00}) : TQ_W'(tex_reg[k]);
    end

    assign sum = SUM_W'(va_reg) * SUM_W'(9'd256 - {1'b0, dr_reg})
               + SUM_W'(vb_reg) * SUM_W'({1'b0, dr_reg}) + SUM_W'(32768);

    // sequencer
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take && hold_type_reg == REQ_LOOKUP)
                    state_next = (h_z < 0) ? S_OUT : S_ZWAIT;
            end
            S_ZWAIT:
            begin
                if (acos_rsp.done)
                    state_next = (acos_rsp.root == 16'd0) ? S_POS1 : S_DIV;
            end
            S_DIV:   if (cnt_reg == 5'd0) state_next = S_AWAIT;
            S_AWAIT: if (acos_rsp.done) state_next = S_POS1;
            S_POS1:  state_next = S_POS2;
            S_POS2:  state_next = S_WRAP;
            S_WRAP:
            begin
                if (c0_reg >= 0 && c0_reg < 14'(cols))
                    state_next = S_RD;
            end
            S_RD:
            begin
                if (rd_cnt_reg[2])
                    state_next = err_reg ? S_OUT : S_BL1;
            end
            S_BL1:   state_next = S_BL2;
            S_BL2:   state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            acos_start_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            acos_start_reg <= (take && hold_type_reg == REQ_LOOKUP && !(h_z < 0))
                           || (state_reg == S_DIV && cnt_reg == 5'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                x_reg       <= h_x;
                y_neg_reg   <= (h_y < 0);
                frame_reg   <= h_frame;
                acos_c_reg  <= 17'(h_z);
                num_reg     <= {x_abs, 15'd0};
                res_reg     <= '0;
                below_reg   <= 1'b1;
                res_err_reg <= 1'b0;
            end
            S_ZWAIT:
            begin
                zen_reg   <= acos_rsp.ang;
                d_reg     <= acos_rsp.root;
                az_reg    <= '0;
                rem_reg   <= '0;
                q_reg     <= '0;
                cnt_reg   <= 5'd30;
                below_reg <= 1'b0;
            end
            S_DIV:
            begin
                rem_reg    <= q_bit ? 16'(trial - {1'b0, d_reg}) : trial[15:0];
                q_reg      <= q_new;
                num_reg    <= {num_reg[29:0], 1'b0};
                cnt_reg    <= cnt_reg - 5'd1;
                acos_c_reg <= (x_reg < 0) ? -17'($signed({1'b0, mag}))
                                          : 17'($signed({1'b0, mag}));
            end
            S_AWAIT:
            begin
                az_reg <= y_neg_reg ? -$signed({1'b0, acos_rsp.ang})
                                    : $signed({1'b0, acos_rsp.ang});
            end
            S_POS1:
            begin
                rprod_reg <= 25'((rows - 9'd1) * zen_reg);
                cprod_reg <= 28'(diff * $signed({1'b0, cols - 9'd1}));
                cr_reg    <= 18'(cols * rows);
            end
            S_POS2:
            begin
                r0_reg   <= (rraw >= 11'(rows)) ? 9'(rraw - 11'(rows)) : rraw[8:0];
                dr_reg   <= rprod_reg[13:6];
                c0_reg   <= 14'(cpos >>> 8);
                dc_reg   <= cpos[7:0];
                base_reg <= 26'(frame_reg * cr_reg);
            end
            S_WRAP:
            begin
                if (c0_reg < 0)
                    c0_reg <= c0_reg + 14'(cols);
                else if (c0_reg >= 14'(cols))
                    c0_reg <= c0_reg - 14'(cols);
                c1_reg      <= c1_comb;
                rowoff0_reg <= 18'(cols * r0_reg);
                rowoff1_reg <= 18'(cols * r1_comb);
                rd_cnt_reg  <= '0;
                err_reg     <= 1'b0;
            end
            S_RD:
            begin
                rd_cnt_reg <= rd_cnt_reg + 3'd1;
                if (!rd_cnt_reg[2] && rd_bad)
                    err_reg <= 1'b1;
                if (rd_cnt_reg != 3'd0)
                    tex_reg[2'(rd_cnt_reg - 3'd1)] <= mem_rdata;
                res_reg     <= '0;
                res_err_reg <= 1'b1;
            end
            S_BL1:
            begin
                va_reg <= VA_W'(tq[0] * (9'd256 - {1'b0, dc_reg}))
                        + VA_W'(tq[1] * {1'b0, dc_reg});
                vb_reg <= VA_W'(tq[2] * (9'd256 - {1'b0, dc_reg}))
                        + VA_W'(tq[3] * {1'b0, dc_reg});
                res_err_reg <= 1'b0;
            end
            S_BL2:
            begin
                if (sum[SUM_W-1:40] != '0)
                    res_reg <= 24'hFF_FFFF;
                else
                    res_reg <= sum[39:16];
            end
            S_OUT: ;
            default: ;
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_rad_reg   <= res_reg;
            out_below_reg <= below_reg;
            out_err_reg   <= res_err_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_rad_reg;
    assign m_axis_tuser  = {out_err_reg, out_below_reg};
endmodule

/* hw/rtl/smbl_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module smbl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end
endmodule

/* hw/rtl/smbl_acos.sv */
// Iterative acos unit: bit-pair square root then 15-step CORDIC vectoring.
// Depends on smbl_pkg.
module smbl_acos (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [16:0]  c,
    output smbl_pkg::acos_rsp_t rsp
);
    import smbl_pkg::*;

    typedef enum logic [5:0] {
        A_IDLE = 6'b000001,
        A_SQ   = 6'b000010,
        A_ROOT = 6'b000100,
        A_INIT = 6'b001000,
        A_ROT  = 6'b010000,
        A_DONE = 6'b100000
    } astate_t;

    astate_t                 state_reg, state_next;
    logic signed [16:0]      c_reg;
    logic [31:0]             v_reg, res_reg, bit_reg;
    logic signed [XY_W-1:0]  x_reg, y_reg;
    logic signed [ANG_W-1:0] ang_reg;
    logic [3:0]              i_reg;
    logic signed [33:0]      sq;
    logic [31:0]             trial;
    logic signed [XY_W-1:0]  sx, sy;

    assign sq    = c_reg * c_reg;
    assign trial = res_reg + bit_reg;
    assign sx    = shr_tz(x_reg, i_reg);
    assign sy    = shr_tz(y_reg, i_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            A_IDLE: if (start) state_next = A_SQ;
            A_SQ:   state_next = A_ROOT;
            A_ROOT: if (bit_reg[0]) state_next = A_INIT;
            A_INIT: state_next = A_ROT;
            A_ROT:  if (i_reg == 4'(CORDIC_STEPS - 1)) state_next = A_DONE;
            A_DONE: state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= A_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            A_IDLE:
            begin
                if (start)
                    c_reg <= c;
            end
            A_SQ:
            begin
                v_reg   <= 32'(34'sd1073741824 - sq);
                res_reg <= '0;
                bit_reg <= 32'h4000_0000;
            end
            A_ROOT:
            begin
                if (v_reg >= trial)
                begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            A_INIT:
            begin
                i_reg <= '0;
                if (c_reg < 0)
                begin
                    x_reg   <= XY_W'({res_reg[16:0], 8'h00});
                    y_reg   <= XY_W'(-c_reg) <<< 8;
                    ang_reg <= 18'sd16384;
                end
                else
                begin
                    x_reg   <= XY_W'(c_reg) <<< 8;
                    y_reg   <= XY_W'({res_reg[16:0], 8'h00});
                    ang_reg <= '0;
                end
            end
            A_ROT:
            begin
                i_reg <= i_reg + 4'd1;
                if (y_reg > 0)
                begin
                    x_reg   <= x_reg + sy;
                    y_reg   <= y_reg - sx;
                    ang_reg <= ang_reg + atan_step(i_reg);
                end
                else
                begin
                    x_reg   <= x_reg - sy;
                    y_reg   <= y_reg + sx;
                    ang_reg <= ang_reg - atan_step(i_reg);
                end
            end
            A_DONE: ;
            default: ;
        endcase
    end

    always_comb
    begin
        rsp.done = (state_reg == A_DONE);
        rsp.root = res_reg[15:0];
        if (ang_reg < 0)
            rsp.ang = '0;
        else if (ang_reg > 18'sd32768)
            rsp.ang = 16'h8000;
        else
            rsp.ang = ang_reg[15:0];
    end
endmodule

/* hw/rtl/smbl_checker.sv */
// Port-level checks for the sky map lookup, bound to the top level.
// Depends on sky_map_bilinear_lookup_top.
module smbl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_below: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 24'd0 && !m_axis_tuser[1])
        else $error("below-horizon word not zero");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 24'd0)
        else $error("address error word not zero");
endmodule

bind sky_map_bilinear_lookup_top smbl_checker u_smbl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* verif/sky_map_bilinear_lookup_top_test.sv */
// Self-checking testbench for sky_map_bilinear_lookup_top: texel writes, ray lookups and
// config writes, with results predicted in-bench and compared word by word.
// Depends on smbl_pkg and the RTL of sky_map_bilinear_lookup_top.
`timescale 1ns / 100ps

module sky_map_bilinear_lookup_top_test;
    import smbl_pkg::*;

    localparam int DEPTH     = 65536;
    localparam int DIM_MAX   = 256;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE    = 200;

    typedef struct {
        logic               kind;
        logic [15:0]        addr;
        logic [15:0]        value;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [7:0]         frame;
    } sky_req_t;

    typedef struct {
        logic [23:0] radiance;
        logic        below;
        logic        addr_err;
    } sky_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_addr;
    logic [15:0] cfg_data;

    sky_map_bilinear_lookup_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    // mirror of block state
    logic [15:0]        texels [DEPTH];
    bit                 texel_known [DEPTH];
    logic [8:0]         rows_reg;
    logic [8:0]         cols_reg;
    logic signed [15:0] sun_reg;
    logic               byte_reg;

    sky_res_t radiance_q [$];
    int       errors;
    int       src_idle_pct;
    int       snk_stall_pct;
    int       idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint trunc_shift(longint v, int k);
        return (v >= 0) ? (v >>> k) : -((-v) >>> k);
    endfunction

    function automatic longint wrap_dim(longint v, longint m);
        longint r;
        r = v % m;
        return (r < 0) ? r + m : r;
    endfunction

    function automatic longint dim_of(logic [8:0] v);
        if (v == 0)
            return 1;
        if (v > DIM_MAX)
            return DIM_MAX;
        return longint'(v);
    endfunction

    // acos of Q1.15 value, in 2^-16 turn units, 15-step CORDIC
    function automatic longint acos_turns(longint c);
        longint s, cx, cy, ang, nx, ny;
        s = longint'(int_sqrt(64'((longint'(1) << 30) - c * c)));
        if (c < 0)
        begin
            cx = s * 256;
            cy = -c * 256;
            ang = 16384;
        end
        else
        begin
            cx = c * 256;
            cy = s * 256;
            ang = 0;
        end
        for (int i = 0; i < 15; i++)
        begin
            if (cy > 0)
            begin
                nx = cx + trunc_shift(cy, i);
                ny = cy - trunc_shift(cx, i);
                ang += atan_step(4'(i));
            end
            else
            begin
                nx = cx - trunc_shift(cy, i);
                ny = cy + trunc_shift(cx, i);
                ang -= atan_step(4'(i));
            end
            cx = nx;
            cy = ny;
        end
        if (ang < 0)
            ang = 0;
        if (ang > 32768)
            ang = 32768;
        return ang;
    endfunction

    // radiance for a lookup; also returns the four texel addresses
    function automatic sky_res_t sample_sky(input sky_req_t rq, output longint adr [4],
                                            output bit reads);
        sky_res_t r;
        longint rows, cols, x, y, z, zen, az, d, mag, a, rpos, cpos;
        longint r0, r1, c0, c1, dr, dc, base, va, vb, res;
        longint t [4];
        r = '{radiance: '0, below: 1'b0, addr_err: 1'b0};
        reads = 0;
        foreach (adr[i])
            adr[i] = 0;
        x = rq.x;
        y = rq.y;
        z = rq.z;
        if (z < 0)
        begin
            r.below = 1'b1;
            return r;
        end
        rows = dim_of(rows_reg);
        cols = dim_of(cols_reg);
        zen = acos_turns(z);
        d = longint'(int_sqrt(64'((longint'(1) << 30) - z * z)));
        if (d == 0)
            az = 0;
        else
        begin
            mag = (((x < 0) ? -x : x) << 15) / d;
            if (mag > 32768)
                mag = 32768;
            a = (x < 0) ? -mag : mag;
            az = acos_turns(a);
            if (y < 0)
                az = -az;
        end
        rpos = ((rows - 1) * zen) >>> 6;
        r0 = wrap_dim(rpos >>> 8, rows);
        dr = rpos & 255;
        r1 = wrap_dim(r0 + 1, rows);
        cpos = (((az - longint'(sun_reg)) * (cols - 1)) >>> 8) + cols * 128;
        c0 = cpos >>> 8;
        dc = cpos - c0 * 256;
        c0 = wrap_dim(c0, cols);
        c1 = wrap_dim(c0 + 1, cols);
        base = longint'(rq.frame) * cols * rows;
        adr[0] = base + cols * r0 + c0;
        adr[1] = base + cols * r0 + c1;
        adr[2] = base + cols * r1 + c0;
        adr[3] = base + cols * r1 + c1;
        for (int i = 0; i < 4; i++)
        begin
            if (adr[i] >= DEPTH)
            begin
                r.addr_err = 1'b1;
                return r;
            end
            t[i] = byte_reg ? (longint'(texels[adr[i]][7:0]) << 8) : longint'(texels[adr[i]]);
        end
        reads = 1;
        va = t[0] * (256 - dc) + t[1] * dc;
        vb = t[2] * (256 - dc) + t[3] * dc;
        res = (va * (256 - dr) + vb * dr + 32768) >>> 16;
        if (res > 24'hFFFFFF)
            res = 24'hFFFFFF;
        r.radiance = 24'(res);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // one word on s_axis; prediction is made when it is accepted
    task automatic send_word(input sky_req_t rq);
        longint   adr [4];
        bit       reads;
        sky_res_t r;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = rq.kind;
        s_axis_tdata  = {rq.frame, rq.z, rq.y, rq.x, rq.value, rq.addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (rq.kind == REQ_WRITE)
        begin
            texels[rq.addr] = rq.value;
            texel_known[rq.addr] = 1;
        end
        else
        begin
            r = sample_sky(rq, adr, reads);
            radiance_q.push_back(r);
        end
    endtask

    function automatic sky_req_t rand_word(logic kind);
        sky_req_t rq;
        rq.kind  = kind;
        rq.addr  = 16'($urandom);
        rq.value = 16'($urandom);
        rq.x     = 16'($urandom);
        rq.y     = 16'($urandom);
        rq.z     = 16'($urandom);
        rq.frame = 8'($urandom);
        return rq;
    endfunction

    task automatic write_texel(input longint a, input logic [15:0] v);
        sky_req_t rq;
        rq = rand_word(REQ_WRITE);
        rq.addr = 16'(a);
        rq.value = v;
        send_word(rq);
    endtask

    // lookup; any texel it would read that is still unwritten gets written first
    task automatic send_lookup(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic signed [15:0] z, input logic [7:0] frame);
        sky_req_t rq;
        sky_res_t r;
        longint   adr [4];
        bit       reads;
        rq = rand_word(REQ_LOOKUP);
        rq.x = x;
        rq.y = y;
        rq.z = z;
        rq.frame = frame;
        r = sample_sky(rq, adr, reads);
        if (reads)
            foreach (adr[i])
                if (!texel_known[adr[i]])
                    write_texel(adr[i], 16'($urandom));
        send_word(rq);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (radiance_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [7:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_addr  = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_ROWS: rows_reg = val[8:0];
            CFG_COLS: cols_reg = val[8:0];
            CFG_SUN:  sun_reg  = val;
            CFG_BYTE: byte_reg = val[0];
            default:  ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [8:0] rows, input logic [8:0] cols,
                              input logic [15:0] sun, input logic bt);
        wait_idle();
        write_cfg(CFG_ROWS, {7'($urandom), rows});
        write_cfg(CFG_COLS, {7'($urandom), cols});
        write_cfg(CFG_SUN, sun);
        write_cfg(CFG_BYTE, {15'($urandom), bt});
    endtask

    // ray that is roughly unit length, or raw random fields
    task automatic random_lookup();
        real    th, ph;
        logic   signed [15:0] x, y, z;
        longint span, maxf;
        logic   [7:0] frame;
        if ($urandom_range(99) < 70)
        begin
            th = ($urandom_range(10000) / 10000.0) * 1.5707963;
            ph = ($urandom_range(20000) / 10000.0 - 1.0) * 3.1415926;
            x = 16'($rtoi(32767.0 * $sin(th) * $cos(ph)));
            y = 16'($rtoi(32767.0 * $sin(th) * $sin(ph)));
            z = 16'($rtoi(32767.0 * $cos(th)));
            if ($urandom_range(99) < 10)
                z = -z - 1;
        end
        else
        begin
            x = 16'($urandom);
            y = 16'($urandom);
            z = 16'($urandom);
        end
        span = dim_of(rows_reg) * dim_of(cols_reg);
        maxf = DEPTH / span;
        if (maxf > 255)
            maxf = 255;
        if ($urandom_range(99) < 10)
            frame = 8'($urandom);
        else
            frame = 8'($urandom_range(int'(maxf)));
        send_lookup(x, y, z, frame);
    endtask

    task automatic random_items(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 25)
                send_word(rand_word(REQ_WRITE));
            else
                random_lookup();
        end
    endtask

    task automatic test_reset_config();
        send_lookup(16'sd0, 16'sd0, 16'sd32767, 8'd0);
        send_lookup(16'sd32767, 16'sd0, 16'sd0, 8'd1);
        send_lookup(-16'sd32768, -16'sd1, 16'sd0, 8'd2);
        send_lookup(16'sd0, 16'sd32767, 16'sd0, 8'd3);
        send_lookup(16'sd0, -16'sd32768, 16'sd100, 8'd7);
        send_lookup(16'sd32767, 16'sd32767, 16'sd1, 8'd0);
        send_lookup(16'sd0, 16'sd0, -16'sd1, 8'd0);
        send_lookup(16'sd5, 16'sd5, -16'sd32768, 8'd255);
        send_lookup(16'sd0, 16'sd0, 16'sd16384, 8'd8);
        send_lookup(16'sd100, -16'sd200, 16'sd30000, 8'd255);
        write_texel(0, 16'hFFFF);
        write_texel(65535, 16'h0000);
    endtask

    task automatic test_config_extremes();
        set_config(9'd2, 9'd2, 16'h8000, 1'b0);
        send_lookup(16'sd0, 16'sd0, 16'sd32767, 8'd0);
        send_lookup(-16'sd32768, 16'sd0, 16'sd0, 8'd255);
        set_config(9'd0, 9'd511, 16'h7FFF, 1'b1);
        send_lookup(16'sd20000, -16'sd20000, 16'sd5000, 8'd200);
        send_lookup(16'sd20000, -16'sd20000, 16'sd5000, 8'd0);
        set_config(9'd257, 9'd1, 16'h0000, 1'b0);
        send_lookup(16'sd0, 16'sd32767, 16'sd0, 8'd255);
        send_lookup(16'sd0, 16'sd32767, 16'sd0, 8'd1);
        set_config(9'd256, 9'd256, 16'h4000, 1'b0);
        send_lookup(16'sd1000, 16'sd1000, 16'sd32000, 8'd0);
        send_lookup(16'sd1000, 16'sd1000, 16'sd32000, 8'd1);
        wait_idle();
        write_cfg(8'd7, 16'hFFFF);
        write_cfg(8'hFF, 16'h0000);
        send_lookup(-16'sd1000, 16'sd1000, 16'sd100, 8'd0);
    endtask

    // each lookup that reads fresh texels also sends up to four texel writes
    task automatic test_random_phase(input int src_pct, input int snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        for (int k = 0; k < 4; k++)
        begin
            set_config(9'($urandom_range(2, 256)), 9'($urandom_range(2, 256)),
                       16'($urandom), 1'($urandom));
            random_items(24);
        end
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);

    always @(posedge clk)
    begin
        sky_res_t r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (radiance_q.size() == 0)
                report_mismatch($sformatf("unexpected result %h/%b", m_axis_tdata, m_axis_tuser));
            else
            begin
                r = radiance_q.pop_front();
                if (m_axis_tdata !== r.radiance)
                    report_mismatch($sformatf("radiance %h, want %h", m_axis_tdata, r.radiance));
                if (m_axis_tuser[0] !== r.below)
                    report_mismatch($sformatf("below_horizon %b, want %b",
                                              m_axis_tuser[0], r.below));
                if (m_axis_tuser[1] !== r.addr_err)
                    report_mismatch($sformatf("address_error %b, want %b",
                                              m_axis_tuser[1], r.addr_err));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_addr      = '0;
        cfg_data      = '0;
        errors        = 0;
        idle_cycles   = 0;
        src_idle_pct  = 35;
        snk_stall_pct = 58;
        rows_reg      = 9'd64;
        cols_reg      = 9'd128;
        sun_reg       = 16'sd0;
        byte_reg      = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_config();
        test_config_extremes();
        test_random_phase(35, 58);
        test_random_phase(58, 35);
        test_random_phase(0, 0);

        wait_idle();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
